// ----- src/olt_pkg.sv -----
// Shared types, codes and controller/datapath interface for the ordered list table.
`default_nettype none

package olt_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned IDX_W    = 5;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
   localparam logic [OP_W-1:0] OP_ROTATE  = 3'd2;
   localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
      logic [IDX_W-1:0]          index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INSERT,
      S_DELETE,
      S_ROTATE,
      S_FLIP,
      S_SHIFT,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic                capture;
      logic                compare;
      logic                insert;
      logic                delete_at;
      logic                rotate;
      logic                flip;
      logic                shift;
      logic                load_k;
      logic                load_gap;
      logic                step;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_read;
      logic                load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            idx_ok;
      logic            k_ok;
      logic            k_full;
      logic            full;
      logic            dup;
      logic            steps_last;
   } stat_type;

endpackage

`default_nettype wire

// ----- src/ordered_list_table_unit.sv -----
// Flow: S_IDLE takes a request and S_DECODE checks it; a read, a rotate by the full count and
// a request rejected by index or op go to S_REPLY. Insert and delete pass S_INSERT or S_DELETE,
// rotate by k below the count makes k one-place rotations in S_ROTATE, reverse flips in S_FLIP
// and shifts DEPTH - count places in S_SHIFT unless full. One transaction at a time; the next
// request is taken in the cycle after the result is registered; a reply waits while one is held.
// Reset: synchronous, active high; clears the entry count and handshake state, not the entries.
`default_nettype none

module ordered_list_table_unit #(
   parameter int unsigned DEPTH = olt_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire olt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output olt_pkg::rsp_type      rsp_data
);
   import olt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   olt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/olt_ctrl.sv -----
// Controller state machine for the ordered list table.
`default_nettype none

module olt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire olt_pkg::stat_type stat,
   output olt_pkg::cmd_type       cmd
);
   import olt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            priority if (stat.op == OP_INSERT) state_in = S_INSERT;
            else if (stat.op == OP_DELETE && stat.idx_ok) state_in = S_DELETE;
            else if (stat.op == OP_ROTATE && stat.k_ok && !stat.k_full) state_in = S_ROTATE;
            else if (stat.op == OP_REVERSE) state_in = S_FLIP;
            else state_in = S_REPLY;
         end
         S_INSERT: state_in = S_REPLY;
         S_DELETE: state_in = S_REPLY;
         S_ROTATE: begin
            if (stat.steps_last) state_in = S_REPLY;
         end
         S_FLIP: begin
            state_in = stat.full ? S_REPLY : S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.steps_last) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.compare    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_RANGE;
            priority if (stat.op == OP_DELETE && stat.idx_ok) begin
               cmd.status = ST_DONE;
            end else if (stat.op == OP_READ && stat.idx_ok) begin
               cmd.status    = ST_DONE;
               cmd.load_read = 1'b1;
            end else if (stat.op == OP_ROTATE && stat.k_ok) begin
               cmd.status = ST_DONE;
               cmd.load_k = 1'b1;
            end else if (stat.op == OP_REVERSE) begin
               cmd.status = ST_DONE;
            end else begin
               cmd.status = ST_RANGE;
            end
         end
         S_INSERT: begin
            cmd.set_status = 1'b1;
            priority if (stat.dup) begin
               cmd.status = ST_DUP;
            end else if (stat.full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.status = ST_DONE;
               cmd.insert = 1'b1;
            end
         end
         S_DELETE: cmd.delete_at = 1'b1;
         S_ROTATE: begin
            cmd.rotate = 1'b1;
            cmd.step   = 1'b1;
         end
         S_FLIP: begin
            cmd.flip     = 1'b1;
            cmd.load_gap = 1'b1;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            cmd.step  = 1'b1;
         end
         S_REPLY: cmd.load_rsp = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- src/olt_datapath.sv -----
// Entry register array, compare vectors, step counter and result register.
`default_nettype none

module olt_datapath #(
   parameter int unsigned DEPTH = olt_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire olt_pkg::req_type req_data,
   input  wire olt_pkg::cmd_type cmd,
   output olt_pkg::stat_type     stat,
   output olt_pkg::rsp_type      rsp_data
);
   import olt_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

   logic signed [VALUE_W-1:0] entry_ff [DEPTH];
   logic signed [VALUE_W-1:0] entry_in [DEPTH];
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic [OP_W-1:0]           op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]          index_ff;
   logic [DEPTH-1:0]          stop_ff;
   logic [DEPTH-1:0]          stop_in;
   logic [DEPTH-1:0]          eq_ff;
   logic [DEPTH-1:0]          eq_in;
   logic [CW-1:0]             steps_ff;
   logic [CW-1:0]             steps_in;
   logic [STATUS_W-1:0]       status_ff;
   logic signed [VALUE_W-1:0] read_ff;
   rsp_type                   rsp_ff;

   logic [XW-1:0]    count_x;
   logic [XW-1:0]    index_x;
   logic [DEPTH-1:0] first;
   logic [DEPTH-1:0] above;

   assign count_x = XW'(count_ff);
   assign index_x = XW'(index_ff);

   assign first = stop_ff & (~stop_ff + 1'b1);
   assign above = ~(first - 1'b1) & ~first;

   assign stat.op         = op_ff;
   assign stat.idx_ok     = index_x < count_x;
   assign stat.k_ok       = (index_x != '0) && (index_x <= count_x);
   assign stat.k_full     = index_x == count_x;
   assign stat.full       = count_ff == CW'(DEPTH);
   assign stat.dup        = |(first & eq_ff);
   assign stat.steps_last = steps_ff == CW'(1);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         stop_in[i] = (XW'(i) >= count_x) || !(entry_ff[i] < value_ff);
         eq_in[i]   = (XW'(i) < count_x) && (entry_ff[i] == value_ff);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) entry_in[i] = value_ff;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (above[i]) entry_in[i] = entry_ff[i-1];
         end
      end else if (cmd.delete_at) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (XW'(i) >= index_x) entry_in[i] = entry_ff[i+1];
         end
      end else if (cmd.rotate) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (XW'(i + 1) < count_x) entry_in[i] = entry_ff[i+1];
         end
         for (int i = 0; i < DEPTH; i++) begin
            if (XW'(i + 1) == count_x) entry_in[i] = entry_ff[0];
         end
      end else if (cmd.flip) begin
         for (int i = 0; i < DEPTH; i++) begin
            entry_in[i] = entry_ff[DEPTH-1-i];
         end
      end else if (cmd.shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
      end else begin
         entry_in = entry_ff;
      end
   end

   always_comb begin
      priority if (cmd.insert) count_in = count_ff + 1'b1;
      else if (cmd.delete_at) count_in = count_ff - 1'b1;
      else count_in = count_ff;
   end

   always_comb begin
      priority if (cmd.load_k) steps_in = CW'(index_ff);
      else if (cmd.load_gap) steps_in = CW'(DEPTH) - count_ff;
      else if (cmd.step) steps_in = steps_ff - 1'b1;
      else steps_in = steps_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      steps_ff <= steps_in;
      if (cmd.capture) begin
         op_ff    <= req_data.op;
         value_ff <= req_data.value;
         index_ff <= req_data.index;
         read_ff  <= '0;
      end
      if (cmd.compare) begin
         stop_ff <= stop_in;
         eq_ff   <= eq_in;
      end
      if (cmd.load_read) read_ff <= entry_ff[IW'(index_ff)];
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.load_rsp) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.count      <= COUNT_W'(count_ff);
         rsp_ff.read_value <= read_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- src/olt_checker.sv -----
// Port-level assertions for the ordered list table, bound to the top level.
`default_nettype none

module olt_checker #(
   parameter int unsigned DEPTH = olt_pkg::DEPTH_DEFAULT
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire olt_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire olt_pkg::rsp_type rsp_data
);
   import olt_pkg::*;

   logic unused_req;
   assign unused_req = ^req_data;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in work");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count == COUNT_W'(DEPTH))
      else $error("list full reported below capacity");

   a_read_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_value != '0 |-> rsp_data.status == ST_DONE)
      else $error("read data on a failed transaction");

endmodule

bind ordered_list_table_unit olt_checker #(
   .DEPTH (DEPTH)
) u_olt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
